@@ src/pwcs_pkg.sv @@
// Shared constants, register codes and stage types for the wall-centering steering PID.
package pwcs_pkg;

  localparam int GAIN_FRAC_BITS = 16;
  localparam int SAMPLE_BITS    = 12;
  localparam int GAIN_W         = 24;
  localparam int INT_W          = 40;

  localparam int ERR_W  = SAMPLE_BITS + 2;
  localparam int DIFF_W = ERR_W + 1;
  localparam int PROD_W = GAIN_W + DIFF_W;
  localparam int SUM_W  = INT_W + 3;

  localparam int IN_TDATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;

  localparam logic [SAMPLE_BITS-1:0] LEFT_OFFSET_RST = SAMPLE_BITS'(100);
  localparam logic [SAMPLE_BITS-1:0] STEER_MIN_RST   = SAMPLE_BITS'(1000);
  localparam logic [SAMPLE_BITS-1:0] STEER_MAX_RST   = SAMPLE_BITS'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN      = 3'd0,
    REG_I_GAIN      = 3'd1,
    REG_D_GAIN      = 3'd2,
    REG_LEFT_OFFSET = 3'd3,
    REG_STEER_MIN   = 3'd4,
    REG_STEER_MAX   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]      p_gain;
    logic [GAIN_W-1:0]      i_gain;
    logic [GAIN_W-1:0]      d_gain;
    logic [SAMPLE_BITS-1:0] left_offset;
    logic [SAMPLE_BITS-1:0] steer_min;
    logic [SAMPLE_BITS-1:0] steer_max;
  } cfg_t;

  typedef struct packed {
    logic [PROD_W-1:0]      p_prod;
    logic [PROD_W-1:0]      d_prod;
    logic [INT_W-1:0]       integ;
    logic [SAMPLE_BITS-1:0] cur_steer;
  } prod_t;

endpackage

@@ src/pid_wall_centering_steer_unit.sv @@
// Top level of the wall-centering steering PID: handshake, stage valids and assertions.
//
//   port group | direction | contents
//   in_*       | slave     | tdata: right_distance, left_distance, current_steer; tuser: kind
//   out_*      | master    | tdata: steer_command; tuser: clamped
//   cfg_*      | slave     | cfg_index selects register, cfg_data is the written value
//
// One request per cycle sustained while out_tready is high; a control step passes the
// input register, product register and result register before it appears at out_tvalid.
// A clear request updates state in the input stage and leaves the pipe even under a stall.
// Reset (rst_n low, synchronous) empties all stages, zeroes the integrator and last error
// and loads the register defaults. A stall at out_tready holds a full product or output stage.
module pid_wall_centering_steer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pwcs_pkg::IN_TDATA_W-1:0]     in_tdata,  // right[11:0] left[23:12] cur[35:24]
  input  logic                                in_tuser,  // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pwcs_pkg::OUT_TDATA_W-1:0]    out_tdata, // steer_command[11:0]
  output logic                                out_tuser, // clamped
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwcs_pkg::GAIN_W-1:0]         cfg_data
);
  import pwcs_pkg::*;

  cfg_t  cfg;
  prod_t prod;

  logic                   a_valid_r, a_valid_nxt;
  logic                   a_kind_r;
  logic [SAMPLE_BITS-1:0] a_right_r, a_left_r, a_cur_r;
  logic                   b_valid_r, b_valid_nxt;
  logic                   o_valid_r, o_valid_nxt;
  logic [SAMPLE_BITS-1:0] steer_r;
  logic                   clamped_r;

  logic in_go, a_go, b_go, out_free, b_free;

  assign out_free  = !o_valid_r || out_tready;
  assign b_go      = b_valid_r && out_free;
  assign b_free    = !b_valid_r || out_free;
  assign a_go      = a_valid_r && (a_kind_r || b_free);
  assign in_tready = !a_valid_r || a_go;
  assign in_go     = in_tvalid && in_tready;

  always_comb begin
    a_valid_nxt = in_go ? 1'b1 : (a_go ? 1'b0 : a_valid_r);
    b_valid_nxt = (a_go && !a_kind_r) ? 1'b1 : (b_go ? 1'b0 : b_valid_r);
    o_valid_nxt = b_go ? 1'b1 : (out_tready ? 1'b0 : o_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      a_kind_r  <= in_tuser;
      a_right_r <= in_tdata[SAMPLE_BITS-1:0];
      a_left_r  <= in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      a_cur_r   <= in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    end
  end

  pwcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwcs_err_stage u_err (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_go        (a_go && !a_kind_r),
    .clear_go       (a_go && a_kind_r),
    .right_distance (a_right_r),
    .left_distance  (a_left_r),
    .current_steer  (a_cur_r),
    .cfg            (cfg),
    .prod_r         (prod)
  );

  pwcs_clamp_stage u_clamp (
    .clk       (clk),
    .load      (b_go),
    .prod      (prod),
    .steer_min (cfg.steer_min),
    .steer_max (cfg.steer_max),
    .steer_r   (steer_r),
    .clamped_r (clamped_r)
  );

  assign out_tvalid = o_valid_r;
  assign out_tdata  = OUT_TDATA_W'(steer_r);
  assign out_tuser  = clamped_r;

  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_kind_r && !b_valid_r) |=> !b_valid_r)
    else $error("clear request produced a result");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !b_valid_r |-> in_tready)
    else $error("input stalled with empty product stage");

  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !out_free) |=> b_valid_r)
    else $error("product stage dropped a stalled request");

  a_b_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    b_go |=> out_tvalid)
    else $error("result lost between product and output stage");

endmodule

@@ src/pwcs_cfg_regs.sv @@
// Configuration register file: gains, left offset and steering limits.
module pwcs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pwcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwcs_pkg::GAIN_W-1:0]      cfg_data,
  output pwcs_pkg::cfg_t                   cfg
);
  import pwcs_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain      <= '0;
      cfg_r.i_gain      <= '0;
      cfg_r.d_gain      <= '0;
      cfg_r.left_offset <= LEFT_OFFSET_RST;
      cfg_r.steer_min   <= STEER_MIN_RST;
      cfg_r.steer_max   <= STEER_MAX_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_P_GAIN:      cfg_r.p_gain      <= cfg_data;
        REG_I_GAIN:      cfg_r.i_gain      <= cfg_data;
        REG_D_GAIN:      cfg_r.d_gain      <= cfg_data;
        REG_LEFT_OFFSET: cfg_r.left_offset <= cfg_data[SAMPLE_BITS-1:0];
        REG_STEER_MIN:   cfg_r.steer_min   <= cfg_data[SAMPLE_BITS-1:0];
        REG_STEER_MAX:   cfg_r.steer_max   <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/pwcs_err_stage.sv @@
// Error, gain products and saturating integrator; holds integrator and last error.
module pwcs_err_stage (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step_go,
  input  logic                               clear_go,
  input  logic [pwcs_pkg::SAMPLE_BITS-1:0]   right_distance,
  input  logic [pwcs_pkg::SAMPLE_BITS-1:0]   left_distance,
  input  logic [pwcs_pkg::SAMPLE_BITS-1:0]   current_steer,
  input  pwcs_pkg::cfg_t                     cfg,
  output pwcs_pkg::prod_t                    prod_r
);
  import pwcs_pkg::*;

  localparam logic [INT_W-1:0] INT_HI = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic [INT_W-1:0] INT_LO = {1'b1, {(INT_W-1){1'b0}}};

  logic signed [INT_W-1:0] integ_r, integ_nxt;
  logic signed [ERR_W-1:0] last_err_r;
  logic signed [ERR_W-1:0] err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] p_prod, i_prod, d_prod;
  logic signed [INT_W:0]    integ_sum;

  always_comb begin
    err = $signed(ERR_W'(right_distance)
          - (ERR_W'(left_distance) + ERR_W'(cfg.left_offset)));
    diff = DIFF_W'(err) - DIFF_W'(last_err_r);
    p_prod = PROD_W'($signed(cfg.p_gain)) * PROD_W'(err);
    i_prod = PROD_W'($signed(cfg.i_gain)) * PROD_W'(err);
    d_prod = PROD_W'($signed(cfg.d_gain)) * PROD_W'(diff);
    integ_sum = (INT_W+1)'(integ_r) + (INT_W+1)'(i_prod);
    if (integ_sum[INT_W] != integ_sum[INT_W-1]) begin
      integ_nxt = integ_sum[INT_W] ? $signed(INT_LO) : $signed(INT_HI);
    end else begin
      integ_nxt = integ_sum[INT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
    end else if (clear_go) begin
      integ_r    <= '0;
      last_err_r <= '0;
    end else if (step_go) begin
      integ_r    <= integ_nxt;
      last_err_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      prod_r.p_prod    <= p_prod;
      prod_r.d_prod    <= d_prod;
      prod_r.integ     <= integ_nxt;
      prod_r.cur_steer <= current_steer;
    end
  end

endmodule

@@ src/pwcs_clamp_stage.sv @@
// PID sum, floor to integer, add to current steering and clamp into the result register.
module pwcs_clamp_stage (
  input  logic                               clk,
  input  logic                               load,
  input  pwcs_pkg::prod_t                    prod,
  input  logic [pwcs_pkg::SAMPLE_BITS-1:0]   steer_min,
  input  logic [pwcs_pkg::SAMPLE_BITS-1:0]   steer_max,
  output logic [pwcs_pkg::SAMPLE_BITS-1:0]   steer_r,
  output logic                               clamped_r
);
  import pwcs_pkg::*;

  logic signed [SUM_W-1:0] sum, sum_int, steer_wide, lo, hi;
  logic [SAMPLE_BITS-1:0]  steer_nxt;
  logic                    clamped_nxt;

  always_comb begin
    sum = SUM_W'($signed(prod.p_prod)) + SUM_W'($signed(prod.integ))
        + SUM_W'($signed(prod.d_prod));
    sum_int    = sum >>> GAIN_FRAC_BITS;
    steer_wide = sum_int + $signed(SUM_W'(prod.cur_steer));
    hi = $signed(SUM_W'(steer_max));
    lo = $signed(SUM_W'(steer_min));
    if (steer_wide > hi) begin
      steer_nxt   = steer_max;
      clamped_nxt = 1'b1;
    end else if (steer_wide < lo) begin
      steer_nxt   = steer_min;
      clamped_nxt = 1'b1;
    end else begin
      steer_nxt   = steer_wide[SAMPLE_BITS-1:0];
      clamped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      steer_r   <= steer_nxt;
      clamped_r <= clamped_nxt;
    end
  end

endmodule
